[hw/rtl/three_channel_pid_color_tracker_unit_defines.svh]
// assertion macros for the pid color tracker
`ifndef THREE_CHANNEL_PID_COLOR_TRACKER_UNIT_DEFINES_SVH
`define THREE_CHANNEL_PID_COLOR_TRACKER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PCT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pct assertion failed");

// antecedent implies consequent in the next cycle
`define PCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pct assertion failed");

`endif

[hw/rtl/pct_pkg.sv]
// shared types and constants of the pid color tracker
package pct_pkg;

  localparam int unsigned MAX_CH     = 4;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned DT_W       = 16;
  localparam int unsigned GAIN_W     = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  // divider: magnitude of the error difference (9 bits) shifted up by 16
  localparam int unsigned DVD_W = 25;
  localparam int unsigned DVS_W = 16;
  localparam int unsigned CNT_W = 5;

  localparam logic [DT_W-1:0] FAST_STEP = 16'd852;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_MODE    = 3'd6;

  // reset values
  localparam logic [COLOR_W-1:0] TARGET_RESET [MAX_CH] = '{8'd10, 8'd250, 8'd255, 8'd0};
  localparam logic [COLOR_W-1:0] COLOR_RESET  [MAX_CH] = '{8'd120, 8'd120, 8'd20, 8'd0};
  localparam logic [GAIN_W-1:0]  KP_RESET = 18'd43254;
  localparam logic [GAIN_W-1:0]  KI_RESET = 18'd2556;
  localparam logic [GAIN_W-1:0]  KD_RESET = 18'd190;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic              fast;
  } gains_t;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctrl_t;

  typedef struct packed {
    logic               done;
    logic [COLOR_W-1:0] color;
  } lane_stat_t;

endpackage

[hw/rtl/three_channel_pid_color_tracker_unit.sv]
// top level of the pid color tracker: config registers, lanes and result merge
// Each request carries one frame time and yields one result with the three
// updated colors and a matched flag. All channels are updated side by side in
// their own lanes, so the time for one update does not depend on the channel
// count; most of it is spent in the 25-step derivative divider in each lane. One
// request is worked on at a time, and the next is taken as soon as the
// previous result sits in the output register.
`include "three_channel_pid_color_tracker_unit_defines.svh"

module three_channel_pid_color_tracker_unit #(
  parameter int unsigned CHANNELS = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [pct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pct_pkg::CFG_DATA_W-1:0]   cfg_data,
  // frame requests
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [15:0]                      s_tdata,   // step_time[15:0]
  // results
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [31:0]                      m_tdata    // color_red[7:0], color_green[15:8],
                                                      // color_blue[23:16], matched[24]
);

  typedef enum logic {T_IDLE, T_RUN} state_t;

  state_t                         state;
  pct_pkg::gains_t                gains;
  logic [pct_pkg::DT_W-1:0]       dt_q;
  pct_pkg::lane_ctrl_t            lane_ctrl;
  pct_pkg::lane_stat_t            lane_stat [CHANNELS];
  logic [CHANNELS-1:0]            lane_done;
  logic [pct_pkg::COLOR_W-1:0]    col [pct_pkg::MAX_CH];
  logic [pct_pkg::COLOR_W-1:0]    tgt [pct_pkg::MAX_CH];
  logic                           all_done;
  logic                           out_load;
  logic                           match;
  logic [31:0]                    out_c;

  // gain and mode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.kp   <= pct_pkg::KP_RESET;
      gains.ki   <= pct_pkg::KI_RESET;
      gains.kd   <= pct_pkg::KD_RESET;
      gains.fast <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pct_pkg::REG_GAIN_P:    gains.kp   <= cfg_data;
        pct_pkg::REG_GAIN_I:    gains.ki   <= cfg_data;
        pct_pkg::REG_GAIN_D:    gains.kd   <= cfg_data;
        pct_pkg::REG_FAST_MODE: gains.fast <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per channel target register and lane
  for (genvar c = 0; c < pct_pkg::MAX_CH; c++) begin : g_ch
    if (c < CHANNELS) begin : g_on
      if (c < 3) begin : g_tgt
        logic [pct_pkg::COLOR_W-1:0] target;
        always_ff @(posedge clk) begin
          if (rst) begin
            target <= pct_pkg::TARGET_RESET[c];
          end else if (cfg_we &&
                       cfg_index == pct_pkg::CFG_IDX_W'(pct_pkg::REG_TARGET_RED + c)) begin
            target <= cfg_data[pct_pkg::COLOR_W-1:0];
          end
        end
        assign tgt[c] = target;
      end else begin : g_notgt
        assign tgt[c] = pct_pkg::TARGET_RESET[c];
      end

      pct_lane #(
        .RESET_COLOR (pct_pkg::COLOR_RESET[c])
      ) u_lane (
        .clk    (clk),
        .rst    (rst),
        .ctrl   (lane_ctrl),
        .gains  (gains),
        .target (tgt[c]),
        .dt     (dt_q),
        .stat   (lane_stat[c])
      );

      assign col[c]       = lane_stat[c].color;
      assign lane_done[c] = lane_stat[c].done;
    end else begin : g_off
      assign col[c] = '0;
      assign tgt[c] = '0;
    end
  end

  // merge lane results
  always_comb begin
    match = 1'b1;
    for (int c = 0; c < pct_pkg::MAX_CH; c++) begin
      if (c < CHANNELS && col[c] != tgt[c]) match = 1'b0;
    end
    out_c = {7'b0, match, col[2], col[1], col[0]};
  end

  assign all_done        = &lane_done;
  assign out_load        = (state == T_RUN) && all_done && (!m_tvalid || m_tready);
  assign s_tready        = (state == T_IDLE);
  assign lane_ctrl.start = s_tvalid && s_tready;
  assign lane_ctrl.ack   = out_load;

  // request sequencing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) m_tvalid <= 1'b0;
      case (state)
        T_IDLE: begin
          if (s_tvalid) begin
            dt_q  <= gains.fast ? pct_pkg::FAST_STEP : s_tdata[15:0];
            state <= T_RUN;
          end
        end
        T_RUN: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            m_tdata  <= out_c;
            state    <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // lanes run in lock step and only while a request is in flight
  `PCT_ASSERT_IMP(a_lanes_lockstep, clk, rst, |lane_done, &lane_done)
  `PCT_ASSERT_IMP(a_done_only_running, clk, rst, |lane_done, state == T_RUN)
  `PCT_ASSERT_NEXT(a_busy_after_request, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule

[hw/rtl/pct_div.sv]
// restoring divider, one quotient bit per cycle
module pct_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pct_pkg::DVD_W-1:0]   dividend,
  input  logic [pct_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [pct_pkg::DVD_W-1:0]   quotient
);

  logic                        busy;
  logic [pct_pkg::CNT_W-1:0]   cnt;
  logic [pct_pkg::DVS_W-1:0]   rem;
  logic [pct_pkg::DVD_W-1:0]   quo;
  logic [pct_pkg::DVS_W:0]     rem_sh;
  logic [pct_pkg::DVS_W:0]     rem_diff;
  logic                        ge;

  // one shift and trial subtract
  always_comb begin
    rem_sh   = {rem, quo[pct_pkg::DVD_W-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    ge       = rem_sh >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        quo <= {quo[pct_pkg::DVD_W-2:0], ge};
        rem <= ge ? rem_diff[pct_pkg::DVS_W-1:0] : rem_sh[pct_pkg::DVS_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == pct_pkg::CNT_W'(pct_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

[hw/rtl/pct_lane.sv]
// one color channel: error, integral, derivative, pid and color update
module pct_lane #(
  parameter logic [7:0] RESET_COLOR = 8'd0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pct_pkg::lane_ctrl_t           ctrl,
  input  pct_pkg::gains_t               gains,
  input  logic [pct_pkg::COLOR_W-1:0]   target,
  input  logic [pct_pkg::DT_W-1:0]      dt,
  output pct_pkg::lane_stat_t           stat
);

  typedef enum logic [3:0] {
    L_IDLE, L_ERR, L_INT, L_DIV, L_MUL, L_SUM, L_TRN, L_PDT, L_COL, L_DONE
  } state_t;

  state_t state;

  // channel state
  logic        [pct_pkg::COLOR_W-1:0] color;
  logic signed [31:0]                 integral;
  logic signed [8:0]                  last_error;

  // working registers
  logic signed [8:0]  err;
  logic signed [9:0]  diff;
  logic signed [25:0] prod_e;
  logic signed [31:0] integ;
  logic signed [27:0] pp;
  logic signed [50:0] pi;
  logic signed [50:0] pd;
  logic signed [52:0] sum;
  logic signed [36:0] pid;
  logic signed [53:0] pdt;

  logic signed [8:0]  err_c;
  logic signed [9:0]  diff_c;
  logic signed [16:0] dt_s;
  logic signed [25:0] prod_e_t;
  logic signed [9:0]  inc;
  logic signed [32:0] integ_sum;
  logic signed [31:0] integ_next;
  logic        [8:0]  diff_mag;
  logic signed [31:0] deriv;
  logic signed [52:0] sum_t;
  logic signed [54:0] vnum;
  logic signed [54:0] vnum_t;
  logic signed [38:0] vq;
  logic [pct_pkg::COLOR_W-1:0] color_next;

  logic                         div_start;
  logic                         div_done;
  logic [pct_pkg::DVD_W-1:0]    quotient;

  // error, difference and integral step
  always_comb begin
    dt_s     = $signed({1'b0, dt});
    err_c    = $signed({1'b0, target}) - $signed({1'b0, color});
    diff_c   = $signed({err_c[8], err_c}) - $signed({last_error[8], last_error});
    prod_e_t = prod_e + (prod_e[25] ? 26'sd65535 : 26'sd0);
    inc      = prod_e_t[25:16];
    integ_sum = $signed({integral[31], integral}) + $signed({{23{inc[9]}}, inc});
    if (gains.fast) begin
      if (integ_sum[32] != integ_sum[31]) begin
        integ_next = integ_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        integ_next = integ_sum[31:0];
      end
    end else if (integ_sum[32]) begin
      integ_next = 32'sd0;
    end else if (|integ_sum[31:8]) begin
      integ_next = 32'sd255;
    end else begin
      integ_next = integ_sum[31:0];
    end
  end

  // derivative from the divider quotient, saturated on a zero step
  always_comb begin
    diff_mag = diff[9] ? 9'(-diff) : diff[8:0];
    if (dt == '0) begin
      if (diff == '0) begin
        deriv = 32'sd0;
      end else begin
        deriv = diff[9] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
    end else if (diff[9]) begin
      deriv = -$signed({7'b0, quotient});
    end else begin
      deriv = $signed({7'b0, quotient});
    end
  end

  // truncating shifts and the color update
  always_comb begin
    sum_t  = sum + (sum[52] ? 53'sd65535 : 53'sd0);
    vnum   = $signed({31'b0, color, 16'b0}) + $signed({pdt[53], pdt});
    vnum_t = vnum + (vnum[54] ? 55'sd65535 : 55'sd0);
    vq     = vnum_t[54:16];
    if (gains.fast) begin
      color_next = pid[7:0];
    end else if (vq[38]) begin
      color_next = '0;
    end else if (|vq[37:8]) begin
      color_next = 8'd255;
    end else begin
      color_next = vq[7:0];
    end
  end

  assign div_start = (state == L_INT);

  pct_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({diff_mag, 16'b0}),
    .divisor  (dt),
    .done     (div_done),
    .quotient (quotient)
  );

  // sequencer and channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= L_IDLE;
      color      <= RESET_COLOR;
      integral   <= '0;
      last_error <= '0;
    end else begin
      case (state)
        L_IDLE: begin
          if (ctrl.start) state <= L_ERR;
        end
        L_ERR: begin
          err    <= err_c;
          diff   <= diff_c;
          prod_e <= err_c * dt_s;
          state  <= L_INT;
        end
        L_INT: begin
          integ <= integ_next;
          state <= L_DIV;
        end
        L_DIV: begin
          if (div_done) state <= L_MUL;
        end
        L_MUL: begin
          pp    <= $signed({1'b0, gains.kp}) * err;
          pi    <= $signed({1'b0, gains.ki}) * integ;
          pd    <= $signed({1'b0, gains.kd}) * deriv;
          state <= L_SUM;
        end
        L_SUM: begin
          sum   <= $signed({{25{pp[27]}}, pp}) + $signed({{2{pi[50]}}, pi})
                   + $signed({{2{pd[50]}}, pd});
          state <= L_TRN;
        end
        L_TRN: begin
          pid   <= sum_t[52:16];
          state <= L_PDT;
        end
        L_PDT: begin
          pdt   <= pid * dt_s;
          state <= L_COL;
        end
        L_COL: begin
          color      <= color_next;
          integral   <= integ;
          last_error <= err;
          state      <= L_DONE;
        end
        L_DONE: begin
          if (ctrl.ack) state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign stat.done  = (state == L_DONE);
  assign stat.color = color;

endmodule

[test/color_update_checker.sv]
// checker for the pid color tracker: mirrors config writes, predicts each result, compares
module color_update_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pct_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [15:0]                    s_tdata,   // step_time[15:0]
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [31:0]                    m_tdata,   // color_red[7:0], color_green[15:8],
                                                    // color_blue[23:16], matched[24]
  output int                             outstanding,
  output int                             fail_count
);
  import pct_pkg::*;

  localparam longint ONE_Q16 = 65536;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam int     NUM_CH  = 3;

  typedef struct packed {
    logic [6:0]         padding;
    logic               matched;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } frame_colors_t;

  // mirrored settings
  logic [COLOR_W-1:0] target_level [NUM_CH];
  logic [GAIN_W-1:0]  p_gain;
  logic [GAIN_W-1:0]  i_gain;
  logic [GAIN_W-1:0]  d_gain;
  logic               fixed_step_mode;

  // per-channel tracker state
  logic [COLOR_W-1:0] shade [NUM_CH];
  longint             accum [NUM_CH];
  longint             prior_error [NUM_CH];

  frame_colors_t expected_colors [$];

  function automatic longint limit(input longint lo, input longint hi, input longint v);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one frame tick over all channels
  function automatic frame_colors_t advance_frame(input logic [15:0] step_time);
    longint        dt;
    longint        err;
    longint        acc;
    longint        diff;
    longint        deriv;
    longint        pid;
    longint        mixed;
    logic          all_equal;
    frame_colors_t res;
    dt = fixed_step_mode ? longint'(FAST_STEP) : longint'(step_time);
    all_equal = 1'b1;
    res = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      err = longint'(target_level[c]) - longint'(shade[c]);
      acc = accum[c] + (err * dt) / ONE_Q16;
      diff = err - prior_error[c];
      if (fixed_step_mode) acc = limit(I32_MIN, I32_MAX, acc);
      else                 acc = limit(0, 255, acc);
      // zero step time: derivative goes to the rail by the sign of the change
      if (dt == 0) begin
        deriv = (diff > 0) ? I32_MAX : ((diff < 0) ? I32_MIN : 0);
      end else begin
        deriv = limit(I32_MIN, I32_MAX, (diff * ONE_Q16) / dt);
      end
      pid = (longint'(p_gain) * err + longint'(i_gain) * acc
             + longint'(d_gain) * deriv) / ONE_Q16;
      if (fixed_step_mode) begin
        shade[c] = pid[7:0];
      end else begin
        mixed = (longint'(shade[c]) * ONE_Q16 + pid * dt) / ONE_Q16;
        shade[c] = 8'(limit(0, 255, mixed));
      end
      accum[c] = acc;
      prior_error[c] = err;
      if (shade[c] != target_level[c]) all_equal = 1'b0;
    end
    res.red = shade[0];
    res.green = shade[1];
    res.blue = shade[2];
    res.matched = all_equal;
    return res;
  endfunction

  // compare one result field
  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    frame_colors_t want;
    frame_colors_t got;
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        target_level[c] = TARGET_RESET[c];
        shade[c] = COLOR_RESET[c];
        accum[c] = 0;
        prior_error[c] = 0;
      end
      p_gain = KP_RESET;
      i_gain = KI_RESET;
      d_gain = KD_RESET;
      fixed_step_mode = 1'b0;
      expected_colors.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      // register writes, masked to register width
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET_RED:   target_level[0] = cfg_data[7:0];
          REG_TARGET_GREEN: target_level[1] = cfg_data[7:0];
          REG_TARGET_BLUE:  target_level[2] = cfg_data[7:0];
          REG_GAIN_P:       p_gain = cfg_data;
          REG_GAIN_I:       i_gain = cfg_data;
          REG_GAIN_D:       d_gain = cfg_data;
          REG_FAST_MODE:    fixed_step_mode = cfg_data[0];
          default: ;
        endcase
      end
      // result side
      if (m_tvalid && m_tready) begin
        if (expected_colors.size() == 0) begin
          $error("result with no request outstanding: tdata %h", m_tdata);
          fail_count++;
        end else begin
          want = expected_colors.pop_front();
          got = m_tdata;
          check_field("color_red", want.red, got.red);
          check_field("color_green", want.green, got.green);
          check_field("color_blue", want.blue, got.blue);
          check_field("matched", want.matched, got.matched);
          check_field("padding", want.padding, got.padding);
        end
      end
      // request side
      if (s_tvalid && s_tready) expected_colors.push_back(advance_frame(s_tdata));
      outstanding <= expected_colors.size();
    end
  end

endmodule

[test/three_channel_pid_color_tracker_unit_tb.sv]
// testbench top for the pid color tracker: stimulus, back-pressure and verdict
module three_channel_pid_color_tracker_unit_tb;
  import pct_pkg::*;

  localparam int                   RANDOM_ITEMS = 1950;
  localparam int                   LIMIT_CYCLES = 1000000;
  localparam int                   HOLD_CYCLES  = 400;
  localparam int                   SETTLE_WAIT  = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 3'd7;
  localparam logic [GAIN_W-1:0]    GAIN_MAX     = 18'h3FFFF;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;   // step_time[15:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;        // color_red[7:0], color_green[15:8],
                                         // color_blue[23:16], matched[24]
  int                    outstanding;
  int                    fail_count;
  int                    cycle_count = 0;
  logic                  no_gaps = 1'b0;

  always #1 clk = ~clk;

  three_channel_pid_color_tracker_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  color_update_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  function automatic logic [15:0] pick_step_time();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(1, 255));
      1:       return 16'($urandom_range(65280, 65535));
      2:       return 16'(1 << $urandom_range(0, 15));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return GAIN_MAX;
      2:       return GAIN_W'($urandom_range(0, 4095));
      3:       return GAIN_W'($urandom_range(0, 65535));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] pick_target();
    case ($urandom_range(0, 4))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // all registers in one go; narrow ones get junk in the unused upper bits
  task automatic load_settings(input logic [COLOR_W-1:0] red, input logic [COLOR_W-1:0] green,
                               input logic [COLOR_W-1:0] blue, input logic [GAIN_W-1:0] kp,
                               input logic [GAIN_W-1:0] ki, input logic [GAIN_W-1:0] kd,
                               input logic fast);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    write_reg(REG_TARGET_RED, {10'($urandom), red});
    write_reg(REG_TARGET_GREEN, {10'($urandom), green});
    write_reg(REG_TARGET_BLUE, {10'($urandom), blue});
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_FAST_MODE, {17'($urandom), fast});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // offer one request, optionally after a random gap
  task automatic send_step(input logic [15:0] step_time);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= step_time;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // result side: random stalls, plus two long hold-offs to fill the block
  initial begin
    int stall;
    int taken;
    taken = 0;
    forever begin
      if (taken == 200 || taken == 1100) stall = HOLD_CYCLES;
      else if (no_gaps) stall = 0;
      else stall = $urandom_range(0, 16);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  // watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int          sent;
    int          run_len;
    logic        settle_run;
    logic        fast;
    logic [15:0] step_time;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: step extremes and zero step time
    send_step(16'd1);
    send_step(16'd65535);
    send_step(16'd0);
    send_step(16'd0);
    send_step(16'd32768);
    send_step(16'd1);
    drain();

    // extreme targets and full-scale gains
    load_settings(8'd0, 8'd255, 8'd0, GAIN_MAX, GAIN_MAX, GAIN_MAX, 1'b0);
    send_step(16'd65535);
    send_step(16'd0);
    send_step(16'd1);
    send_step(16'd21845);
    drain();

    // fast mode, zero gains then full gains
    load_settings(8'd255, 8'd0, 8'd128, '0, '0, '0, 1'b1);
    send_step(16'd0);
    send_step(16'd65535);
    drain();
    load_settings(8'd128, 8'd64, 8'd200, GAIN_MAX, GAIN_MAX, GAIN_MAX, 1'b1);
    send_step(16'd1);
    send_step(16'd2);
    send_step(16'd3);
    drain();

    // back to normal mode: the fast-mode integral gets clamped
    load_settings(8'd255, 8'd0, 8'd128, KP_RESET, KI_RESET, KD_RESET, 1'b0);
    send_step(16'd0);
    send_step(16'd40000);
    send_step(16'd65535);
    send_step(16'd1);
    drain();

    // random runs, each under its own settings
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      run_len = $urandom_range(10, 80);
      if (run_len > RANDOM_ITEMS - sent) run_len = RANDOM_ITEMS - sent;
      no_gaps = ($urandom_range(0, 3) == 0);
      // settling runs use the default gains so colors converge and match
      settle_run = ($urandom_range(0, 3) == 0);
      fast = !settle_run && ($urandom_range(0, 3) == 0);
      if (settle_run) begin
        load_settings(pick_target(), pick_target(), pick_target(),
                      KP_RESET, KI_RESET, KD_RESET, 1'b0);
      end else begin
        load_settings(pick_target(), pick_target(), pick_target(),
                      pick_gain(), pick_gain(), pick_gain(), fast);
      end
      for (int k = 0; k < run_len; k++) begin
        step_time = settle_run ? 16'($urandom_range(8192, 40000)) : pick_step_time();
        send_step(step_time);
      end
      sent += run_len;
      drain();
    end
    no_gaps = 1'b0;

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
